@@ rtl/slstk_pkg.sv @@
// Shared types and constants for the searchable LIFO stack.
package slstk_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FILL_W      = 5;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic modify;
  } cell_ctrl_t;

endpackage

@@ rtl/searchable_lifo_stack.sv @@
// Top level of the searchable LIFO stack: a row of cells with the top entry in cell 0.
// Output: the result of an accepted item is in the output register in the next cycle.
// Throughput: one item per cycle while the output is not stalled; push and pop
// shift every cell, the match chain across all cells settles within the same cycle.
// Reset: asynchronous, empties the stack; words held in the cells are not cleared.
module searchable_lifo_stack import slstk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  logic signed [WORD_W-1:0] key_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic                     found_o,
  output logic signed [WORD_W-1:0] top_word_o,
  output logic [FILL_W-1:0]        fill_count_o
);

  action_e           action;
  logic              accept;
  logic              full, empty, found;
  logic [CNT_W-1:0]  count_q, count_d;
  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] cmp_word;

  logic [WORD_W-1:0] word     [STACK_DEPTH];
  logic              occ      [STACK_DEPTH];
  logic [WORD_W-1:0] word_nx  [STACK_DEPTH];
  logic              occ_nx   [STACK_DEPTH];
  logic              hit      [STACK_DEPTH+1];

  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic              found_q;
  logic [WORD_W-1:0] top_q, top_d;
  logic [FILL_W-1:0] fill_q;

  assign action     = action_e'(action_i);
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CNT_W'(STACK_DEPTH));
  assign empty      = (count_q == '0);
  assign cmp_word   = (action == ACT_MODIFY) ? key_i : value_i;

  assign ctrl.push   = accept && (action == ACT_PUSH) && !full;
  assign ctrl.pop    = accept && (action == ACT_POP) && !empty;
  assign ctrl.modify = accept && (action == ACT_MODIFY);

  assign hit[0] = 1'b0;
  assign found  = hit[STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_word, dn_word;
    logic              up_occ, dn_occ;
    if (i == 0) begin : g_top
      assign up_word = value_i;
      assign up_occ  = 1'b1;
    end else begin : g_mid
      assign up_word = word[i-1];
      assign up_occ  = occ[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_word = '0;
      assign dn_occ  = 1'b0;
    end else begin : g_up
      assign dn_word = word[i+1];
      assign dn_occ  = occ[i+1];
    end
    slstk_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .value_i     (value_i),
      .cmp_i       (cmp_word),
      .up_word_i   (up_word),
      .up_occ_i    (up_occ),
      .dn_word_i   (dn_word),
      .dn_occ_i    (dn_occ),
      .hit_above_i (hit[i]),
      .word_o      (word[i]),
      .occ_o       (occ[i]),
      .word_next_o (word_nx[i]),
      .occ_next_o  (occ_nx[i]),
      .hit_above_o (hit[i+1])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CNT_W'(1);
    end
    unique case (action)
      ACT_PUSH: begin
        if (full) status_d = ST_FULL;
      end
      ACT_POP: begin
        if (empty) status_d = ST_EMPTY;
      end
      ACT_MODIFY, ACT_SEARCH: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: status_d = ST_OK;
    endcase
    if (ctrl.pop) begin
      top_d = word[0];
    end else if (occ_nx[0]) begin
      top_d = word_nx[0];
    end else begin
      top_d = '0;
    end
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= found && (status_d == ST_OK) &&
                  ((action == ACT_MODIFY) || (action == ACT_SEARCH));
      top_q    <= top_d;
      fill_q   <= FILL_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign top_word_o   = top_q;
  assign fill_count_o = fill_q;

endmodule

@@ rtl/slstk_cell.sv @@
// One stack cell: holds a word, shifts on push or pop, compares and rewrites on modify.
module slstk_cell import slstk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic [WORD_W-1:0] cmp_i,
  input  logic [WORD_W-1:0] up_word_i,
  input  logic              up_occ_i,
  input  logic [WORD_W-1:0] dn_word_i,
  input  logic              dn_occ_i,
  input  logic              hit_above_i,
  output logic [WORD_W-1:0] word_o,
  output logic              occ_o,
  output logic [WORD_W-1:0] word_next_o,
  output logic              occ_next_o,
  output logic              hit_above_o
);

  logic [WORD_W-1:0] word_q, word_d;
  logic              occ_q, occ_d;
  logic              match;

  assign match       = occ_q && (word_q == cmp_i);
  assign hit_above_o = hit_above_i | match;

  always_comb begin
    word_d = word_q;
    occ_d  = occ_q;
    if (ctrl_i.push) begin
      word_d = up_word_i;
      occ_d  = up_occ_i;
    end else if (ctrl_i.pop) begin
      word_d = dn_word_i;
      occ_d  = dn_occ_i;
    end else if (ctrl_i.modify && match && !hit_above_i) begin
      word_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o      = word_q;
  assign occ_o       = occ_q;
  assign word_next_o = word_d;
  assign occ_next_o  = occ_d;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the searchable LIFO stack: directed table, random actions, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import slstk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int DIR_ROWS    = 21;

  typedef struct packed {
    status_e                  status;
    logic                     found;
    logic signed [WORD_W-1:0] top;
    logic [FILL_W-1:0]        fill;
  } stack_result_t;

  typedef struct packed {
    action_e                  act;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] key;
    logic [7:0]               reps;
    logic                     typed;
    stack_result_t            res;
  } dir_row_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               action_i     = ACT_PUSH;
  logic signed [WORD_W-1:0] value_i      = '0;
  logic signed [WORD_W-1:0] key_i        = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [1:0]               status_o;
  logic                     found_o;
  logic signed [WORD_W-1:0] top_word_o;
  logic [FILL_W-1:0]        fill_count_o;

  logic signed [WORD_W-1:0] held_words [STACK_DEPTH];
  int                       held_cnt = 0;
  stack_result_t            pending_q [$];

  int in_idle_pct  = 6;
  int out_idle_pct = 72;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int cycle_cnt    = 0;
  int err_cnt      = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int full_hits    = 0;
  int empty_hits   = 0;
  int miss_hits    = 0;
  int match_hits   = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ACT_POP,    32'sd0,           32'sd0,           8'd1,  1'b1,
      '{ST_EMPTY,     1'b0, 32'sd0,           5'd0}},
    '{ACT_MODIFY, 32'sd5,           32'sd5,           8'd1,  1'b1,
      '{ST_EMPTY,     1'b0, 32'sd0,           5'd0}},
    '{ACT_SEARCH, 32'sd0,           32'sd0,           8'd1,  1'b1,
      '{ST_EMPTY,     1'b0, 32'sd0,           5'd0}},
    '{ACT_PUSH,   32'sh7fffffff,    32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b0, 32'sh7fffffff,    5'd1}},
    '{ACT_PUSH,   32'sh80000000,    32'sh7fffffff,    8'd1,  1'b1,
      '{ST_OK,        1'b0, 32'sh80000000,    5'd2}},
    '{ACT_SEARCH, 32'sh7fffffff,    32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b1, 32'sh80000000,    5'd2}},
    '{ACT_SEARCH, 32'sh80000000,    32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b1, 32'sh80000000,    5'd2}},
    '{ACT_SEARCH, 32'sd0,           32'sh80000000,    8'd1,  1'b1,
      '{ST_NOT_FOUND, 1'b0, 32'sh80000000,    5'd2}},
    '{ACT_MODIFY, 32'sh12345678,    32'sh11111111,    8'd1,  1'b1,
      '{ST_NOT_FOUND, 1'b0, 32'sh80000000,    5'd2}},
    '{ACT_PUSH,   32'sh7fffffff,    32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b0, 32'sh7fffffff,    5'd3}},
    '{ACT_MODIFY, -32'sd1,          32'sh7fffffff,    8'd1,  1'b1,
      '{ST_OK,        1'b1, -32'sd1,          5'd3}},
    '{ACT_SEARCH, 32'sh7fffffff,    32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b1, -32'sd1,          5'd3}},
    '{ACT_MODIFY, 32'sd0,           32'sh80000000,    8'd1,  1'b1,
      '{ST_OK,        1'b1, -32'sd1,          5'd3}},
    '{ACT_POP,    32'sd0,           32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b0, -32'sd1,          5'd2}},
    '{ACT_POP,    32'sd0,           32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b0, 32'sd0,           5'd1}},
    '{ACT_PUSH,   32'sh0a5a5a50,    32'sd0,           8'd15, 1'b0, '0},
    '{ACT_PUSH,   32'sh55555555,    32'sd0,           8'd1,  1'b1,
      '{ST_FULL,      1'b0, 32'sh0a5a5a5e,    5'd16}},
    '{ACT_SEARCH, 32'sh7fffffff,    32'sd0,           8'd1,  1'b1,
      '{ST_OK,        1'b1, 32'sh0a5a5a5e,    5'd16}},
    '{ACT_MODIFY, 32'shdeadbeef,    32'sh7fffffff,    8'd1,  1'b0, '0},
    '{ACT_SEARCH, -32'sd1,          32'sh7fffffff,    8'd1,  1'b0, '0},
    '{ACT_POP,    32'sd0,           32'sd0,           8'd4,  1'b0, '0}
  };

  searchable_lifo_stack u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_o      (found_o),
    .top_word_o   (top_word_o),
    .fill_count_o (fill_count_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic stack_result_t apply_action(input action_e act,
                                                 input logic signed [WORD_W-1:0] val,
                                                 input logic signed [WORD_W-1:0] key);
    stack_result_t            res;
    logic signed [WORD_W-1:0] probe;
    int                       hit;
    bit                       popped;
    res    = '0;
    res.status = ST_OK;
    popped = 1'b0;
    hit    = -1;
    probe  = (act == ACT_MODIFY) ? key : val;
    for (int i = held_cnt - 1; i >= 0; i--) begin
      if (hit < 0 && held_words[i] == probe) hit = i;
    end
    case (act)
      ACT_PUSH: begin
        if (held_cnt >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_words[held_cnt] = val;
          held_cnt++;
        end
      end
      ACT_POP: begin
        if (held_cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held_cnt--;
          res.top = held_words[held_cnt];
          popped  = 1'b1;
        end
      end
      default: begin
        if (held_cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          if (act == ACT_MODIFY) held_words[hit] = val;
          res.found = 1'b1;
        end
      end
    endcase
    if (!popped) res.top = (held_cnt == 0) ? '0 : held_words[held_cnt-1];
    res.fill = held_cnt[FILL_W-1:0];
    case (res.status)
      ST_FULL:      full_hits++;
      ST_EMPTY:     empty_hits++;
      ST_NOT_FOUND: miss_hits++;
      default:      if (res.found) match_hits++;
    endcase
    return res;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && held_cnt > 0) return held_words[$urandom_range(0, held_cnt - 1)];
    if (roll < 70) begin
      case ($urandom_range(0, 5))
        0:       return 32'sd0;
        1:       return -32'sd1;
        2:       return 32'sh7fffffff;
        3:       return 32'sh80000000;
        4:       return 32'sd1;
        default: return 32'sh5a5a5a5a;
      endcase
    end
    return $urandom;
  endfunction

  // Present one item, hold it until accepted, then queue its result.
  task automatic send_item(input action_e act, input logic signed [WORD_W-1:0] val,
                           input logic signed [WORD_W-1:0] key, input bit typed,
                           input stack_result_t typed_res);
    stack_result_t res;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    key_i      <= key;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_action(act, val, key);
    pending_q.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    action_e act;
    int      roll;
    bit      fill_mode;
    fill_mode = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (n % 24 == 0) fill_mode = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (fill_mode) begin
        act = (roll < 55) ? ACT_PUSH : (roll < 70) ? ACT_POP :
              (roll < 85) ? ACT_MODIFY : ACT_SEARCH;
      end else begin
        act = (roll < 20) ? ACT_PUSH : (roll < 55) ? ACT_POP :
              (roll < 78) ? ACT_MODIFY : ACT_SEARCH;
      end
      send_item(act, pick_word(), pick_word(), 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    stack_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d top_word %0d", status_o, top_word_o);
        err_cnt++;
      end else begin
        exp_res = pending_q.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          err_cnt++;
        end
        if (found_o !== exp_res.found) begin
          $error("found: expected %0d, got %0d", exp_res.found, found_o);
          err_cnt++;
        end
        if (top_word_o !== exp_res.top) begin
          $error("top_word: expected %0d, got %0d", exp_res.top, top_word_o);
          err_cnt++;
        end
        if (fill_count_o !== exp_res.fill) begin
          $error("fill_count: expected %0d, got %0d", exp_res.fill, fill_count_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[r]) begin
      for (int i = 0; i < dir_tab[r].reps; i++) begin
        send_item(dir_tab[r].act, dir_tab[r].value + i, dir_tab[r].key,
                  dir_tab[r].typed, dir_tab[r].res);
      end
    end
    run_random(220);
    in_valid_i <= 1'b0;
    drain_results();

    in_idle_pct  = 72;
    out_idle_pct = 6;
    run_random(220);
    in_valid_i <= 1'b0;
    drain_results();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_reqs++;
    run_random(210);
    in_valid_i <= 1'b0;
    drain_results();
    repeat (8) @(negedge clk_i);

    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      err_cnt++;
    end
    $display("Run covered %0d items and %0d results over %0d cycles.",
             items_sent, results_seen, cycle_cnt);
    $display("Outcomes seen: %0d full, %0d empty, %0d not found, %0d matched.",
             full_hits, empty_hits, miss_hits, match_hits);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
